FILE: hw/rtl/rkd_pkg.sv
`timescale 1ns / 1ps

package rkd_pkg;

  // operand and derived widths
  localparam int OPERAND_WIDTH = 8;
  localparam int TOT_W         = 2 * OPERAND_WIDTH;
  localparam int FIELD_W       = 16;

  // result status codes
  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_FIRST_BAD   = 3'd1,
    ST_SECOND_BAD  = 3'd2,
    ST_NOT_COPRIME = 3'd3,
    ST_TOO_BIG     = 3'd4
  } status_t;

  // input item
  typedef struct packed {
    logic [OPERAND_WIDTH-1:0] first_prime;
    logic [OPERAND_WIDTH-1:0] second_prime;
    logic [OPERAND_WIDTH-1:0] public_exponent;
  } in_item_t;

  // result item
  typedef struct packed {
    status_t              status;
    logic [FIELD_W-1:0]   modulus;
    logic [FIELD_W-1:0]   totient;
    logic [FIELD_W-1:0]   private_exponent;
  } out_item_t;

endpackage

FILE: hw/rtl/rsa_key_derivation.sv
`timescale 1ns / 1ps

// RSA key derivation from caller-supplied candidates.
// Input channel (in_valid / in_stall / in_item): two prime candidates and a
// public exponent. Result channel (out_valid / out_stall / out_item): one
// item per input item with status, modulus, totient and private exponent.
// Both candidates are checked by trial division, the exponent by Euclid's
// algorithm, and the private exponent is found by stepping k = 1 + m*totient
// until the exponent divides it. All divisions go through one shared
// bit-serial divider of 2*OPERAND_WIDTH bits. Latency is data dependent:
// trial divisions by 2 up to half of each candidate, then one division per
// Euclid step, one division, and the inverse steps (fewer than e).
// Rejected items finish early.
// One item is worked on at a time: in_stall stays high from acceptance until
// the result has been loaded into the output register.
// While the receiver stalls, the result waits in the output register and no
// new item is accepted once the next result is ready.
// Reset (rst_n low, synchronous) returns the sequencer to idle and drops
// out_valid; nothing needs clearing.

module rsa_key_derivation
  import rkd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  localparam int W = OPERAND_WIDTH;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PRIME,
    S_PTEST,
    S_PWAIT,
    S_MULN,
    S_MULT,
    S_GCD_INIT,
    S_GCD,
    S_GCD_WAIT,
    S_INV_DIV,
    S_INV_LOOP,
    S_OUT
  } state_t;

  state_t             state_r;
  logic [W-1:0]       p_r;
  logic [W-1:0]       q_r;
  logic [W-1:0]       e_r;
  logic               sel_r;
  logic [W-1:0]       div_r;
  logic [TOT_W-1:0]   mod_r;
  logic [TOT_W-1:0]   tot_r;
  logic [TOT_W-1:0]   a_r;
  logic [TOT_W-1:0]   b_r;
  logic [W-1:0]       step_r;
  logic [FIELD_W-1:0] qt_r;
  logic [W-1:0]       rem_r;
  logic [FIELD_W-1:0] quo_r;
  logic [W-1:0]       m_r;
  status_t            status_r;
  logic               out_valid_r;
  out_item_t          out_item_r;

  logic               dv_start_r;
  logic [TOT_W-1:0]   dvd_r;
  logic [TOT_W-1:0]   dsr_r;
  logic [TOT_W-1:0]   dv_quo;
  logic [TOT_W-1:0]   dv_rem;
  logic               dv_done;

  // shared divider
  rkd_divider #(
    .WIDTH(TOT_W)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (dv_start_r),
    .dividend  (dvd_r),
    .divisor   (dsr_r),
    .quotient  (dv_quo),
    .remainder (dv_rem),
    .done      (dv_done)
  );

  // candidate under test
  logic [W-1:0] cand;
  logic [W-1:0] cand_half;
  assign cand      = sel_r ? q_r : p_r;
  assign cand_half = cand >> 1;

  // shared multiplier for modulus and totient
  logic [W-1:0]     mul_a;
  logic [W-1:0]     mul_b;
  logic [TOT_W-1:0] mul_prod;
  always_comb begin
    if (state_r == S_MULN) begin
      mul_a = p_r;
      mul_b = q_r;
    end else begin
      mul_a = p_r - W'(1);
      mul_b = q_r - W'(1);
    end
  end
  assign mul_prod = {{W{1'b0}}, mul_a} * {{W{1'b0}}, mul_b};

  // one inverse step: k += totient, track k / e and k mod e
  logic [W-1:0]       rem_base;
  logic [FIELD_W-1:0] quo_base;
  logic [W-1:0]       step_src;
  logic [FIELD_W-1:0] qt_src;
  logic [W:0]         inv_sum;
  logic               inv_carry;
  logic [W-1:0]       rem_nxt;
  logic [FIELD_W-1:0] quo_nxt;
  always_comb begin
    if (state_r == S_INV_DIV) begin
      rem_base = (e_r == W'(1)) ? '0 : W'(1);
      quo_base = (e_r == W'(1)) ? FIELD_W'(1) : '0;
      step_src = dv_rem[W-1:0];
      qt_src   = FIELD_W'(dv_quo);
    end else begin
      rem_base = rem_r;
      quo_base = quo_r;
      step_src = step_r;
      qt_src   = qt_r;
    end
    inv_sum   = {1'b0, rem_base} + {1'b0, step_src};
    inv_carry = (inv_sum >= {1'b0, e_r});
    rem_nxt   = inv_carry ? W'(inv_sum - {1'b0, e_r}) : inv_sum[W-1:0];
    quo_nxt   = quo_base + qt_src + FIELD_W'(inv_carry);
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      dv_start_r  <= 1'b0;
    end else begin
      // result register: set when a result is loaded, cleared once taken
      if (state_r == S_OUT && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            p_r      <= in_item.first_prime;
            q_r      <= in_item.second_prime;
            e_r      <= in_item.public_exponent;
            sel_r    <= 1'b0;
            status_r <= ST_OK;
            state_r  <= S_PRIME;
          end
        end
        S_PRIME: begin
          if (cand < W'(2)) begin
            status_r <= sel_r ? ST_SECOND_BAD : ST_FIRST_BAD;
            state_r  <= S_OUT;
          end else begin
            div_r   <= W'(2);
            state_r <= S_PTEST;
          end
        end
        S_PTEST: begin
          if (div_r > cand_half) begin
            if (sel_r) begin
              state_r <= S_MULN;
            end else begin
              sel_r   <= 1'b1;
              state_r <= S_PRIME;
            end
          end else begin
            dvd_r      <= TOT_W'(cand);
            dsr_r      <= TOT_W'(div_r);
            dv_start_r <= 1'b1;
            state_r    <= S_PWAIT;
          end
        end
        S_PWAIT: begin
          dv_start_r <= 1'b0;
          if (dv_done) begin
            if (dv_rem == '0) begin
              status_r <= sel_r ? ST_SECOND_BAD : ST_FIRST_BAD;
              state_r  <= S_OUT;
            end else begin
              div_r   <= div_r + W'(1);
              state_r <= S_PTEST;
            end
          end
        end
        S_MULN: begin
          mod_r   <= mul_prod;
          state_r <= S_MULT;
        end
        S_MULT: begin
          tot_r   <= mul_prod;
          state_r <= S_GCD_INIT;
        end
        S_GCD_INIT: begin
          if (e_r == '0) begin
            status_r <= ST_NOT_COPRIME;
            state_r  <= S_OUT;
          end else begin
            a_r     <= TOT_W'(e_r);
            b_r     <= tot_r;
            state_r <= S_GCD;
          end
        end
        S_GCD: begin
          if (b_r == '0) begin
            if (a_r != TOT_W'(1)) begin
              status_r <= ST_NOT_COPRIME;
              state_r  <= S_OUT;
            end else if (TOT_W'(e_r) > tot_r) begin
              status_r <= ST_TOO_BIG;
              state_r  <= S_OUT;
            end else begin
              dvd_r      <= tot_r;
              dsr_r      <= TOT_W'(e_r);
              dv_start_r <= 1'b1;
              state_r    <= S_INV_DIV;
            end
          end else begin
            dvd_r      <= a_r;
            dsr_r      <= b_r;
            dv_start_r <= 1'b1;
            state_r    <= S_GCD_WAIT;
          end
        end
        S_GCD_WAIT: begin
          dv_start_r <= 1'b0;
          if (dv_done) begin
            a_r     <= b_r;
            b_r     <= dv_rem;
            state_r <= S_GCD;
          end
        end
        S_INV_DIV: begin
          dv_start_r <= 1'b0;
          if (dv_done) begin
            step_r  <= dv_rem[W-1:0];
            qt_r    <= FIELD_W'(dv_quo);
            rem_r   <= rem_nxt;
            quo_r   <= quo_nxt;
            m_r     <= W'(1);
            state_r <= S_INV_LOOP;
          end
        end
        S_INV_LOOP: begin
          if (rem_r == '0 || m_r >= e_r) begin
            state_r <= S_OUT;
          end else begin
            rem_r <= rem_nxt;
            quo_r <= quo_nxt;
            m_r   <= m_r + W'(1);
          end
        end
        S_OUT: begin
          if (!out_valid_r || !out_stall) begin
            out_item_r.status   <= status_r;
            if (status_r == ST_FIRST_BAD || status_r == ST_SECOND_BAD) begin
              out_item_r.modulus <= '0;
              out_item_r.totient <= '0;
            end else begin
              out_item_r.modulus <= FIELD_W'(mod_r);
              out_item_r.totient <= FIELD_W'(tot_r);
            end
            out_item_r.private_exponent <= (status_r == ST_OK) ? quo_r : '0;
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

FILE: hw/rtl/rkd_divider.sv
`timescale 1ns / 1ps

module rkd_divider
  import rkd_pkg::*;
#(
  parameter int WIDTH = TOT_W
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [WIDTH-1:0] dividend,
  input  logic [WIDTH-1:0] divisor,
  output logic [WIDTH-1:0] quotient,
  output logic [WIDTH-1:0] remainder,
  output logic             done
);

  localparam int CNT_W = $clog2(WIDTH + 1);

  logic [WIDTH-1:0] quo_r;
  logic [WIDTH-1:0] rem_r;
  logic [CNT_W-1:0] cnt_r;
  logic             done_r;

  logic [WIDTH:0]   shifted;
  logic [WIDTH:0]   diff;
  logic             ge;

  // one restoring step per cycle
  assign shifted = {rem_r, quo_r[WIDTH-1]};
  assign ge      = (shifted >= {1'b0, divisor});
  assign diff    = shifted - {1'b0, divisor};

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else if (start) begin
      cnt_r  <= CNT_W'(WIDTH);
      done_r <= 1'b0;
    end else begin
      done_r <= (cnt_r == CNT_W'(1));
      if (cnt_r != '0) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
    end else if (cnt_r != '0) begin
      quo_r <= {quo_r[WIDTH-2:0], ge};
      rem_r <= ge ? diff[WIDTH-1:0] : shifted[WIDTH-1:0];
    end
  end

  assign quotient  = quo_r;
  assign remainder = rem_r;
  assign done      = done_r;

endmodule
